// ===== rtl/rgbw_linear_fader_macros.svh =====
// assertion macros shared by the fader checker
`ifndef RGBW_LINEAR_FADER_MACROS_SVH
`define RGBW_LINEAR_FADER_MACROS_SVH

// condition holds in the same cycle as the trigger
`define RLF_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("rgbw_linear_fader check failed");

// condition holds in the cycle after the trigger
`define RLF_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("rgbw_linear_fader check failed");

`endif

// ===== rtl/rlf_pkg.sv =====
// shared types and constants of the rgbw linear fader
package rlf_pkg;

    localparam int LANES   = 4;
    localparam int LEVEL_W = 8;
    localparam int DELTA_W = LEVEL_W + 1;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 10;

    // one quotient bit per magnitude bit in the serial lerp
    localparam int MAG_STEPS = LEVEL_W;

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 10'd40;

    // request item modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [DELTA_W-1:0] delta_t;

    typedef struct packed {
        logic                mode;
        logic [LEVEL_W-1:0]  target_red;
        logic [LEVEL_W-1:0]  target_green;
        logic [LEVEL_W-1:0]  target_blue;
        logic [LEVEL_W-1:0]  target_white;
        logic [TIME_W-1:0]   fade_ms;
    } rlf_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level_red;
        logic [LEVEL_W-1:0]  level_green;
        logic [LEVEL_W-1:0]  level_blue;
        logic [LEVEL_W-1:0]  level_white;
        logic [TIME_W-1:0]   remaining_ms;
        logic                active;
        logic                fading;
    } rlf_out_t;

    // controller to lerp unit
    typedef struct packed {
        logic                go;
        logic                neg;
        logic [LEVEL_W-1:0]  start;
        logic [LEVEL_W-1:0]  mag;
    } rlf_lerp_req_t;

    // lerp unit to controller
    typedef struct packed {
        logic                done;
        logic [LEVEL_W-1:0]  level;
    } rlf_lerp_rsp_t;

endpackage

// ===== rtl/rlf_lerp.sv =====
// bit-serial multiply-divide computing start +/- trunc(elapsed * mag / fade)
module rlf_lerp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rlf_pkg::rlf_lerp_req_t     req,
    input  logic [rlf_pkg::TIME_W-1:0] elapsed_ms,
    input  logic [rlf_pkg::TIME_W-1:0] fade_ms,
    output rlf_pkg::rlf_lerp_rsp_t     rsp
);
    import rlf_pkg::*;

    localparam int CNT_W = $clog2(MAG_STEPS);
    localparam int ACC_W = TIME_W + 2;

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     step_cnt_reg;
    logic [LEVEL_W-1:0]   mag_reg;
    logic                 neg_reg;
    logic [LEVEL_W-1:0]   start_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [LEVEL_W-1:0]   quo_reg;

    logic [ACC_W-1:0]     addend;
    logic [ACC_W-1:0]     acc;
    logic [ACC_W-1:0]     fade_x1;
    logic [ACC_W-1:0]     fade_x2;
    logic [ACC_W-1:0]     acc_red;
    logic [1:0]           digit;
    logic [TIME_W-1:0]    rem_next;
    logic [LEVEL_W:0]     quo_wide;
    logic [LEVEL_W-1:0]   quo_next;
    logic [LEVEL_W+1:0]   level_sum;
    logic [LEVEL_W-1:0]   level_out;

    // one long-division step: shift in one magnitude bit worth of elapsed time
    always_comb begin
        addend   = mag_reg[LEVEL_W-1] ? {2'b00, elapsed_ms} : '0;
        acc      = {1'b0, rem_reg, 1'b0} + addend;
        fade_x1  = {2'b00, fade_ms};
        fade_x2  = {1'b0, fade_ms, 1'b0};
        priority if (acc >= fade_x2) begin
            acc_red = acc - fade_x2;
            digit   = 2'd2;
        end else if (acc >= fade_x1) begin
            acc_red = acc - fade_x1;
            digit   = 2'd1;
        end else begin
            acc_red = acc;
            digit   = 2'd0;
        end
        rem_next = acc_red[TIME_W-1:0];
        quo_wide = {quo_reg, 1'b0} + {{(LEVEL_W-1){1'b0}}, digit};
        quo_next = quo_wide[LEVEL_W-1:0];
    end

    // apply quotient to start level with clamping
    always_comb begin
        if (neg_reg) begin
            level_sum = {2'b00, start_reg} - {2'b00, quo_reg};
        end else begin
            level_sum = {2'b00, start_reg} + {2'b00, quo_reg};
        end
        priority if (level_sum[LEVEL_W+1]) begin
            level_out = '0;
        end else if (level_sum[LEVEL_W]) begin
            level_out = '1;
        end else begin
            level_out = level_sum[LEVEL_W-1:0];
        end
    end

    // step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            done_reg     <= 1'b0;
            step_cnt_reg <= '0;
        end else if (req.go) begin
            busy_reg     <= 1'b1;
            done_reg     <= 1'b0;
            step_cnt_reg <= '0;
        end else if (busy_reg) begin
            step_cnt_reg <= step_cnt_reg + 1'b1;
            if (step_cnt_reg == CNT_W'(MAG_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // datapath shift registers
    always_ff @(posedge aclk) begin
        if (req.go) begin
            mag_reg   <= req.mag;
            neg_reg   <= req.neg;
            start_reg <= req.start;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end else if (busy_reg) begin
            mag_reg <= {mag_reg[LEVEL_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.level = level_out;

endmodule

// ===== rtl/rgbw_linear_fader.sv =====
// rgbw linear fader top level: request handling, fade state and result register
//
// Usage: s_valid/s_ready/s_data carry one request (mode 0 starts a fade to new
// targets over fade_ms, mode 1 is a time tick). Every request gives exactly
// one result on m_valid/m_ready/m_data with the four levels, remaining time,
// active and fading marks. cfg_valid/cfg_ready/cfg_data write tick_step_ms;
// cfg_ready is always high, write only while the block is idle.
// Flow: a start request, or a tick with no fade running, goes from idle to
// the emit state. A tick first goes to the check state; if it ends the fade it
// then goes to emit, and a tick inside the fade runs the four lanes in turn
// through one shared serial multiply-divide unit, one magnitude bit per step
// for each lane, before emit. The emit state writes the result once the
// output register is free and returns to idle, where the next request is taken.
// One request is worked on at a time; s_ready is high only when
// no request is in work, and a new request may be taken while the previous
// result still waits in the output register.
// Reset (aresetn low, synchronous) clears all levels, targets and times,
// drops fading and active, sets tick_step_ms to 40 and empties the output.
// When the receiver stalls the finished result holds in the output register
// and the block waits before writing the next one.
module rgbw_linear_fader (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  rlf_pkg::rlf_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output rlf_pkg::rlf_out_t           m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rlf_pkg::STEP_W-1:0]  cfg_data
);
    import rlf_pkg::*;

    localparam int LANE_W = $clog2(LANES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_LERP,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   tick_step_reg;
    level_t              shown_reg  [LANES];
    level_t              start_reg  [LANES];
    delta_t              delta_reg  [LANES];
    level_t              target_reg [LANES];
    logic [TIME_W-1:0]   fade_reg;
    logic [TIME_W-1:0]   elapsed_reg;
    logic                running_reg;
    logic                power_reg;
    logic [LANE_W-1:0]   lane_reg;
    logic                go_reg;
    logic                go_next;
    logic                m_valid_reg;
    rlf_out_t            m_data_reg;

    level_t              target_in [LANES];
    logic [TIME_W:0]     elapsed_sum;
    logic [TIME_W-1:0]   elapsed_next;
    logic                all_zero;
    logic [TIME_W-1:0]   remaining;
    delta_t              lane_delta;
    delta_t              lane_mag;
    rlf_lerp_req_t       lerp_req;
    rlf_lerp_rsp_t       lerp_rsp;
    logic                out_free;

    // new targets by lane
    assign target_in[0] = s_data.target_red;
    assign target_in[1] = s_data.target_green;
    assign target_in[2] = s_data.target_blue;
    assign target_in[3] = s_data.target_white;

    // saturating elapsed time
    always_comb begin
        elapsed_sum  = {1'b0, elapsed_reg} + {{(TIME_W + 1 - STEP_W){1'b0}}, tick_step_reg};
        elapsed_next = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
    end

    // status terms
    always_comb begin
        all_zero = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            if (target_reg[i] != '0) begin
                all_zero = 1'b0;
            end
        end
        remaining = (running_reg && (elapsed_reg < fade_reg)) ? (fade_reg - elapsed_reg) : '0;
    end

    // lerp request for the current lane
    always_comb begin
        lane_delta     = delta_reg[lane_reg];
        lane_mag       = lane_delta[DELTA_W-1] ? (~lane_delta + 1'b1) : lane_delta;
        lerp_req.go    = go_reg;
        lerp_req.neg   = lane_delta[DELTA_W-1];
        lerp_req.start = start_reg[lane_reg];
        lerp_req.mag   = lane_mag[LEVEL_W-1:0];
    end

    // start the lerp unit on the first lane and after each finished lane but the last
    assign go_next = ((state_reg == S_CHECK) && (elapsed_reg < fade_reg))
                  || ((state_reg == S_LERP) && lerp_rsp.done
                      && (lane_reg != LANE_W'(LANES - 1)));

    rlf_lerp u_rlf_lerp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (lerp_req),
        .elapsed_ms (elapsed_reg),
        .fade_ms    (fade_reg),
        .rsp        (lerp_rsp)
    );

    assign out_free = !m_valid_reg || m_ready;

    // sequencer, fade state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            tick_step_reg <= TICK_STEP_RESET;
            for (int i = 0; i < LANES; i++) begin
                shown_reg[i]  <= '0;
                start_reg[i]  <= '0;
                delta_reg[i]  <= '0;
                target_reg[i] <= '0;
            end
            fade_reg      <= '0;
            elapsed_reg   <= '0;
            running_reg   <= 1'b0;
            power_reg     <= 1'b0;
            lane_reg      <= '0;
            go_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            go_reg <= go_next;

            // config write
            if (cfg_valid) begin
                tick_step_reg <= cfg_data;
            end

            // result taken with nothing new to write
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_data.mode == MODE_START) begin
                            for (int i = 0; i < LANES; i++) begin
                                start_reg[i]  <= target_reg[i];
                                delta_reg[i]  <= {1'b0, target_in[i]} - {1'b0, target_reg[i]};
                                target_reg[i] <= target_in[i];
                            end
                            fade_reg    <= s_data.fade_ms;
                            elapsed_reg <= '0;
                            running_reg <= 1'b1;
                            power_reg   <= 1'b1;
                            state_reg   <= S_EMIT;
                        end else if (running_reg) begin
                            elapsed_reg <= elapsed_next;
                            state_reg   <= S_CHECK;
                        end else begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_CHECK: begin
                    if (elapsed_reg >= fade_reg) begin
                        for (int i = 0; i < LANES; i++) begin
                            shown_reg[i] <= target_reg[i];
                        end
                        fade_reg    <= '0;
                        running_reg <= 1'b0;
                        if (all_zero) begin
                            power_reg <= 1'b0;
                        end
                        state_reg <= S_EMIT;
                    end else begin
                        lane_reg  <= '0;
                        state_reg <= S_LERP;
                    end
                end
                S_LERP: begin
                    if (lerp_rsp.done) begin
                        shown_reg[lane_reg] <= lerp_rsp.level;
                        if (lane_reg == LANE_W'(LANES - 1)) begin
                            state_reg <= S_EMIT;
                        end else begin
                            lane_reg <= lane_reg + 1'b1;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_data_reg.level_red    <= shown_reg[0];
                        m_data_reg.level_green  <= shown_reg[1];
                        m_data_reg.level_blue   <= shown_reg[2];
                        m_data_reg.level_white  <= shown_reg[3];
                        m_data_reg.remaining_ms <= remaining;
                        m_data_reg.active       <= power_reg;
                        m_data_reg.fading       <= running_reg;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

// ===== rtl/rlf_checker.sv =====
// port-level checker for the rgbw linear fader and its bind
`include "rgbw_linear_fader_macros.svh"

module rlf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input rlf_pkg::rlf_out_t  m_data
);
    import rlf_pkg::*;

    // a stalled result holds
    `RLF_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // one request in work at a time
    `RLF_ASSERT_NEXT(a_one_in_work, s_valid && s_ready, !s_ready)

    // no time left once the fade is over
    `RLF_ASSERT_NOW(a_idle_no_time, m_valid && !m_data.fading, m_data.remaining_ms == '0)

    // a running fade keeps power on
    `RLF_ASSERT_NOW(a_fade_powered, m_valid && m_data.fading, m_data.active)

endmodule

bind rgbw_linear_fader rlf_checker u_rlf_checker (.*);
